/* sv/tlpt_pkg.sv */
// Shared constants and types of the two-level page table store.
package tlpt_pkg;

    localparam int DIR_SLOTS         = 1024;
    localparam int DIR_AW            = $clog2(DIR_SLOTS);
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int TBL_IDX_W         = $clog2(ENTRIES_PER_TABLE);
    localparam int BACKED_DIR_SLOTS  = 16;
    localparam int TBL_DEPTH         = BACKED_DIR_SLOTS * ENTRIES_PER_TABLE;
    localparam int TBL_AW            = $clog2(TBL_DEPTH);
    localparam int PAGE_SHIFT        = 12;
    localparam int ADDR_W            = 32;
    localparam int ATTR_W            = 12;

    typedef enum logic [1:0] {
        OP_XLATE   = 2'd0,
        OP_SET_DIR = 2'd1,
        OP_SET_TBL = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_DIR_ABSENT = 2'd1,
        ST_TBL_ABSENT = 2'd2,
        ST_RANGE      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_TBL
    } t_state;

endpackage

/* sv/two_level_page_table_store_unit.sv */
// Two-level page table store: directory and table memories with a walk sequencer.
//
// After reset the block sweeps both memories to zero, one entry per cycle, over
// TBL_DEPTH table entries (16384 with 16 backed directory slots) and accepts no
// transfer until the sweep ends. An accepted item first reads its directory entry
// from the directory memory. A translate that finds a present entry in a backed
// slot then reads the table memory, and the next item is not taken before that
// read; directory writes, table writes and early failures finish in the directory
// cycle and run at one per cycle while the output register is free. The next item
// is accepted in the cycle in which the current one hands its result to the
// output register, and a directory write in that cycle is forwarded to the next
// item's read.
module two_level_page_table_store_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [11:0] i_attr_bits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_phys_result
);

    localparam int DAW = tlpt_pkg::DIR_AW;
    localparam int TAW = tlpt_pkg::TBL_AW;
    localparam int TIW = tlpt_pkg::TBL_IDX_W;
    localparam int PAGE_SHIFT_HI = tlpt_pkg::PAGE_SHIFT + TIW - 1;

    // Memories
    logic [31:0] r_dir_mem [tlpt_pkg::DIR_SLOTS];
    logic [31:0] r_tbl_mem [tlpt_pkg::TBL_DEPTH];
    logic [31:0] r_dir_rdata;
    logic [31:0] r_tbl_rdata;

    logic           dir_we;
    logic [DAW-1:0] dir_waddr;
    logic [31:0]    dir_wdata;
    logic           dir_re;
    logic [DAW-1:0] dir_raddr;
    logic           tbl_we;
    logic           tbl_re;
    logic [TAW-1:0] tbl_addr;
    logic [31:0]    tbl_wdata;

    // Sequencer and item registers
    tlpt_pkg::t_state r_state, n_state;
    logic [TAW-1:0]   r_clr_cnt;
    logic [1:0]       r_op;
    logic [31:0]      r_va;
    logic [31:0]      r_entry;
    logic             r_fwd_hit;
    logic [31:0]      r_fwd_data;

    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [31:0]      r_result;

    logic             accept;
    logic             out_free;
    logic             finish;
    logic             advance;
    logic             needs_tbl;
    logic [31:0]      dir_entry;
    logic [DAW-1:0]   cur_dir;
    logic             in_range;
    tlpt_pkg::t_status res_status;
    logic [31:0]      res_value;
    logic             clr_last;

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re) begin
            r_dir_rdata <= r_dir_mem[dir_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_addr] <= tbl_wdata;
        end
        if (tbl_re) begin
            r_tbl_rdata <= r_tbl_mem[tbl_addr];
        end
    end

    assign cur_dir   = r_va[31:22];
    assign dir_entry = r_fwd_hit ? r_fwd_data : r_dir_rdata;
    assign in_range  = {1'b0, cur_dir} < (DAW+1)'(tlpt_pkg::BACKED_DIR_SLOTS);
    assign out_free  = !r_out_valid || i_out_ready;
    assign clr_last  = r_clr_cnt == TAW'(tlpt_pkg::TBL_DEPTH - 1);

    // Per-state decision: result code and whether the table must be read.
    always_comb begin
        needs_tbl  = 1'b0;
        finish     = 1'b0;
        res_status = tlpt_pkg::ST_OK;
        res_value  = '0;
        if (r_state == tlpt_pkg::S_DIR) begin
            case (r_op)
                tlpt_pkg::OP_XLATE: begin
                    if (!dir_entry[0]) begin
                        res_status = tlpt_pkg::ST_DIR_ABSENT;
                    end else if (!in_range) begin
                        res_status = tlpt_pkg::ST_RANGE;
                    end else begin
                        needs_tbl = 1'b1;
                    end
                end
                tlpt_pkg::OP_SET_DIR: res_status = tlpt_pkg::ST_OK;
                tlpt_pkg::OP_SET_TBL: begin
                    if (!dir_entry[0]) begin
                        res_status = tlpt_pkg::ST_DIR_ABSENT;
                    end else if (!in_range) begin
                        res_status = tlpt_pkg::ST_RANGE;
                    end
                end
                default: res_status = tlpt_pkg::ST_RANGE;
            endcase
            finish = !needs_tbl;
        end else if (r_state == tlpt_pkg::S_TBL) begin
            finish = 1'b1;
            if (r_tbl_rdata[0]) begin
                res_value = {r_tbl_rdata[31:tlpt_pkg::PAGE_SHIFT],
                             r_va[tlpt_pkg::PAGE_SHIFT-1:0]};
            end else begin
                res_status = tlpt_pkg::ST_TBL_ABSENT;
            end
        end
    end

    assign advance    = finish && out_free;
    assign o_in_ready = (r_state == tlpt_pkg::S_IDLE) || advance;
    assign accept     = i_in_valid && o_in_ready;

    // Memory port control.
    always_comb begin
        dir_re    = accept;
        dir_raddr = i_virt_addr[31:22];
        tbl_re    = needs_tbl;
        tbl_addr  = TAW'({cur_dir, r_va[PAGE_SHIFT_HI:tlpt_pkg::PAGE_SHIFT]});
        if (r_state == tlpt_pkg::S_CLEAR) begin
            dir_we    = 1'b1;
            dir_waddr = r_clr_cnt[DAW-1:0];
            dir_wdata = '0;
            tbl_we    = 1'b1;
            tbl_addr  = r_clr_cnt;
            tbl_wdata = '0;
        end else begin
            dir_we    = advance && (r_state == tlpt_pkg::S_DIR) && (r_op == tlpt_pkg::OP_SET_DIR);
            dir_waddr = cur_dir;
            dir_wdata = r_entry;
            tbl_we    = advance && (r_state == tlpt_pkg::S_DIR) &&
                        (r_op == tlpt_pkg::OP_SET_TBL) && dir_entry[0] && in_range;
            tbl_wdata = r_entry;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlpt_pkg::S_CLEAR: begin
                if (clr_last) begin
                    n_state = tlpt_pkg::S_IDLE;
                end
            end
            tlpt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = tlpt_pkg::S_DIR;
                end
            end
            tlpt_pkg::S_DIR: begin
                if (needs_tbl) begin
                    n_state = tlpt_pkg::S_TBL;
                end else if (advance) begin
                    n_state = accept ? tlpt_pkg::S_DIR : tlpt_pkg::S_IDLE;
                end
            end
            tlpt_pkg::S_TBL: begin
                if (advance) begin
                    n_state = accept ? tlpt_pkg::S_DIR : tlpt_pkg::S_IDLE;
                end
            end
            default: n_state = tlpt_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlpt_pkg::S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tlpt_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + TAW'(1);
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // A directory write in the accept cycle is not seen by the read port.
            if (accept) begin
                r_fwd_hit <= dir_we && (i_virt_addr[31:22] == cur_dir);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_opcode;
            r_va       <= i_virt_addr;
            r_entry    <= {i_phys_addr[31:tlpt_pkg::PAGE_SHIFT], i_attr_bits};
            r_fwd_data <= r_entry;
        end
        if (advance) begin
            r_status <= res_status;
            r_result <= res_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_phys_result = r_result;

    // A table walk cycle always follows a directory cycle or holds itself.
    a_tbl_after_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlpt_pkg::S_TBL) |->
            ($past(r_state) == tlpt_pkg::S_DIR || $past(r_state) == tlpt_pkg::S_TBL))
        else $error("table stage entered without a directory read");

    // Outside the clearing sweep, table writes only come from a valid set-table item.
    a_tbl_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_we && r_state != tlpt_pkg::S_CLEAR) |->
            (r_op == tlpt_pkg::OP_SET_TBL && dir_entry[0] && in_range))
        else $error("table written by an item that may not write it");

    // No transfer is taken and no result is produced during the clearing sweep.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlpt_pkg::S_CLEAR) |-> (!accept && !r_out_valid))
        else $error("activity during the clearing sweep");

endmodule

/* dv/page_walk_checker.sv */
// Checker that predicts and compares every result of the two-level page table store.
module page_walk_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [11:0] i_attr_bits,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_phys_result,
    output int          o_pending,
    output int          o_mismatches
);

    typedef struct packed {
        tlpt_pkg::t_status status;
        logic [31:0]       phys;
    } t_walk_resp;

    logic [31:0] dir_mem [tlpt_pkg::DIR_SLOTS];
    logic [31:0] tbl_mem [tlpt_pkg::TBL_DEPTH];
    t_walk_resp  expected_walks [$];

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        o_mismatches = o_mismatches + 1;
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Applies one operation to the shadow directory and tables and returns what the
    // block should answer.
    function automatic t_walk_resp walk_tables(input logic [1:0] op,
                                               input logic [31:0] va,
                                               input logic [31:0] pa,
                                               input logic [11:0] attr);
        logic [9:0]  dir_idx;
        logic [9:0]  tbl_idx;
        logic [31:0] dir_entry;
        logic [31:0] tbl_entry;
        logic [31:0] new_entry;
        int          slot;
        t_walk_resp  resp;

        dir_idx   = va[31:22];
        tbl_idx   = va[21:12];
        dir_entry = dir_mem[dir_idx];
        new_entry = {pa[31:12], attr};
        slot      = int'(dir_idx) * tlpt_pkg::ENTRIES_PER_TABLE + int'(tbl_idx);
        resp.status = tlpt_pkg::ST_OK;
        resp.phys   = '0;
        case (op)
            tlpt_pkg::OP_XLATE: begin
                // The present check on the directory comes ahead of the range check.
                if (!dir_entry[0]) begin
                    resp.status = tlpt_pkg::ST_DIR_ABSENT;
                end else if (int'(dir_idx) >= tlpt_pkg::BACKED_DIR_SLOTS) begin
                    resp.status = tlpt_pkg::ST_RANGE;
                end else begin
                    tbl_entry = tbl_mem[slot];
                    if (!tbl_entry[0]) begin
                        resp.status = tlpt_pkg::ST_TBL_ABSENT;
                    end else begin
                        resp.phys = {tbl_entry[31:12], va[11:0]};
                    end
                end
            end
            tlpt_pkg::OP_SET_DIR: begin
                dir_mem[dir_idx] = new_entry;
            end
            tlpt_pkg::OP_SET_TBL: begin
                if (!dir_entry[0]) begin
                    resp.status = tlpt_pkg::ST_DIR_ABSENT;
                end else if (int'(dir_idx) >= tlpt_pkg::BACKED_DIR_SLOTS) begin
                    resp.status = tlpt_pkg::ST_RANGE;
                end else begin
                    tbl_mem[slot] = new_entry;
                end
            end
            default: begin
                resp.status = tlpt_pkg::ST_RANGE;
            end
        endcase
        return resp;
    endfunction

    always @(posedge i_clk) begin
        t_walk_resp want;

        if (!i_rst_n) begin
            for (int i = 0; i < tlpt_pkg::DIR_SLOTS; i++) dir_mem[i] = '0;
            for (int i = 0; i < tlpt_pkg::TBL_DEPTH; i++) tbl_mem[i] = '0;
            expected_walks.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_walks.push_back(walk_tables(i_opcode, i_virt_addr,
                                                     i_phys_addr, i_attr_bits));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_walks.size() == 0) begin
                    flag_mismatch("result with no transfer outstanding",
                                  i_phys_result, 32'h0);
                end else begin
                    want = expected_walks.pop_front();
                    if (i_status !== want.status) begin
                        flag_mismatch("status", 32'(i_status), 32'(want.status));
                    end
                    if (i_phys_result !== want.phys) begin
                        flag_mismatch("phys_result", i_phys_result, want.phys);
                    end
                end
            end
        end
        o_pending <= expected_walks.size();
    end

endmodule

/* dv/two_level_page_table_store_unit_tb.sv */
// Testbench top for the two-level page table store: stimulus, back pressure and verdict.
module two_level_page_table_store_unit_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode    = tlpt_pkg::OP_XLATE;
    logic [31:0] virt_addr = '0;
    logic [31:0] phys_addr = '0;
    logic [11:0] attr_bits = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [31:0] phys_result;
    int          pending;
    int          mismatches;
    bit          steady    = 1'b0;

    two_level_page_table_store_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_opcode      (opcode),
        .i_virt_addr   (virt_addr),
        .i_phys_addr   (phys_addr),
        .i_attr_bits   (attr_bits),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_phys_result (phys_result)
    );

    page_walk_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_opcode      (opcode),
        .i_virt_addr   (virt_addr),
        .i_phys_addr   (phys_addr),
        .i_attr_bits   (attr_bits),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_phys_result (phys_result),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 16);
    end

    function automatic logic [31:0] vaddr(input logic [9:0] dir_idx,
                                          input logic [9:0] tbl_idx,
                                          input logic [11:0] offset);
        return {dir_idx, tbl_idx, offset};
    endfunction

    // Presents one item and returns at the edge where its transfer happens, with
    // valid still high.
    task automatic put_item(input logic [1:0] op, input logic [31:0] va,
                            input logic [31:0] pa, input logic [11:0] attr);
        while (!steady && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        virt_addr <= va;
        phys_addr <= pa;
        attr_bits <= attr;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        logic [1:0]  op;
        logic [9:0]  dir_idx;
        logic [9:0]  tbl_idx;
        logic [31:0] va;
        logic [11:0] attr;
        int unsigned pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk through the status codes and the field extremes.
        put_item(tlpt_pkg::OP_XLATE,   32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        put_item(tlpt_pkg::OP_SET_TBL, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        put_item(tlpt_pkg::OP_SET_DIR, vaddr(10'd0, 10'd0, 12'h0), 32'hFFFF_FFFF, 12'hFFF);
        put_item(tlpt_pkg::OP_XLATE,   vaddr(10'd0, 10'd0, 12'hABC), 32'h0, 12'h0);
        put_item(tlpt_pkg::OP_SET_TBL, vaddr(10'd0, 10'd1023, 12'h0), 32'hFFFF_FFFF,
                 12'hFFF);
        put_item(tlpt_pkg::OP_XLATE,   32'h003F_FFFF, 32'h0, 12'h0);
        put_item(tlpt_pkg::OP_SET_DIR, 32'hFFFF_FFFF, 32'h0000_0000, 12'h001);
        put_item(tlpt_pkg::OP_XLATE,   32'hFFFF_FFFF, 32'h0, 12'h0);
        put_item(tlpt_pkg::OP_SET_TBL, 32'hFFC0_0000, 32'hFFFF_FFFF, 12'hFFF);
        put_item(tlpt_pkg::OP_SET_DIR, vaddr(10'd15, 10'd0, 12'h0), 32'h1234_5678, 12'h001);
        put_item(tlpt_pkg::OP_SET_TBL, vaddr(10'd15, 10'd0, 12'h0), 32'h0000_0000, 12'h001);
        put_item(tlpt_pkg::OP_XLATE,   vaddr(10'd15, 10'd0, 12'hFFF), 32'h0, 12'h0);
        put_item(tlpt_pkg::OP_SET_TBL, vaddr(10'd15, 10'd1, 12'h0), 32'hFFFF_F000, 12'hFFE);
        put_item(tlpt_pkg::OP_XLATE,   vaddr(10'd15, 10'd1, 12'h0), 32'h0, 12'h0);
        // Slot 16 is the first directory slot without table storage.
        put_item(tlpt_pkg::OP_SET_DIR, vaddr(10'd16, 10'd0, 12'h0), 32'h0000_0000, 12'h001);
        put_item(tlpt_pkg::OP_XLATE,   vaddr(10'd16, 10'd0, 12'h0), 32'h0, 12'h0);
        put_item(tlpt_pkg::OP_SET_TBL, vaddr(10'd16, 10'd0, 12'h0), 32'h5555_5000, 12'h001);
        put_item(OP_UNUSED,            32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        // Clearing the present bit hides the table; setting it again exposes it.
        put_item(tlpt_pkg::OP_SET_DIR, vaddr(10'd0, 10'd0, 12'h0), 32'h0000_0000, 12'h000);
        put_item(tlpt_pkg::OP_XLATE,   32'h003F_FFFF, 32'h0, 12'h0);
        put_item(tlpt_pkg::OP_SET_DIR, vaddr(10'd0, 10'd0, 12'h0), 32'hA5A5_A000, 12'h5A1);
        put_item(tlpt_pkg::OP_XLATE,   32'h003F_F123, 32'h0, 12'h0);

        for (int n = 0; n < 1080; n++) begin
            steady = (n >= 300 && n < 500);
            if (n == 700) drain();
            pick    = $urandom_range(99);
            dir_idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(19));
            tbl_idx = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(7));
            va      = vaddr(dir_idx, tbl_idx, 12'($urandom));
            attr    = 12'($urandom);
            if (pick < 50) begin
                op = tlpt_pkg::OP_XLATE;
            end else if (pick < 62) begin
                op      = tlpt_pkg::OP_SET_DIR;
                attr[0] = ($urandom_range(99) < 85);
            end else if (pick < 94) begin
                op      = tlpt_pkg::OP_SET_TBL;
                attr[0] = ($urandom_range(99) < 80);
            end else if (pick < 97) begin
                op = tlpt_pkg::OP_XLATE;
                va = $urandom;
            end else begin
                op = OP_UNUSED;
                va = $urandom;
            end
            put_item(op, va, $urandom, attr);
        end
        steady = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
